// ----- src/dri_pkg.sv -----
// shared types, constants and helper functions of the date rotation index block
// no dependencies; every other file imports this package
package dri_pkg;

  localparam int COUNT_BITS_DEF = 8;

  localparam int YEAR_W = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int WDAY_W = 3;
  localparam int CFG_W = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int BIDX_W = 3;
  localparam int IDX_W = 8;
  localparam int DNUM_W = 22;
  localparam int QUOT_W = 8;
  localparam int DOY_W = 9;

  localparam logic [YEAR_W-1:0] YEAR_FIRST = YEAR_W'(1970);
  localparam logic [YEAR_W-1:0] YEAR_LAST = YEAR_W'(9999);
  localparam logic [WDAY_W-1:0] WDAY_LIMIT = WDAY_W'(7);

  // floor(x / 25) for x below 4096 as (x * 1311) >> 15
  localparam int DIV25_MUL = 1311;
  localparam int DIV25_SHIFT = 15;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CUSTOM  = 2'd0,
    REG_BUILTIN = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic              live;
    logic              ok;
    logic              uses_custom;
    logic [BIDX_W-1:0] bidx;
  } dri_tag_t;

  function automatic logic [QUOT_W-1:0] div25(input logic [11:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(DIV25_MUL);
    return p[DIV25_SHIFT +: QUOT_W];
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2: n = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: n = DAY_W'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
      default: n = '0;
    endcase
    return n;
  endfunction

  // days before the first of the month, year counted from march
  function automatic logic [DOY_W-1:0] doy_base(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      4'd3: n = DOY_W'(0);
      4'd4: n = DOY_W'(31);
      4'd5: n = DOY_W'(61);
      4'd6: n = DOY_W'(92);
      4'd7: n = DOY_W'(122);
      4'd8: n = DOY_W'(153);
      4'd9: n = DOY_W'(184);
      4'd10: n = DOY_W'(214);
      4'd11: n = DOY_W'(245);
      4'd12: n = DOY_W'(275);
      4'd1: n = DOY_W'(306);
      4'd2: n = DOY_W'(337);
      default: n = '0;
    endcase
    return n;
  endfunction

  // weekday mod count; weekday is below 8 so a few subtractions suffice
  function automatic logic [BIDX_W-1:0] small_mod(input logic [WDAY_W-1:0] w,
                                                  input logic [CFG_W-1:0] b);
    logic [CFG_W-1:0] r;
    r = CFG_W'(w);
    for (int i = 0; i < 7; i++) begin
      if (b != '0 && r >= b) begin
        r = r - b;
      end
    end
    return r[BIDX_W-1:0];
  endfunction

endpackage

// ----- src/dri_in_if.sv -----
// date request channel: valid/ready handshake with the date and weekday fields
// depends on dri_pkg
interface dri_in_if import dri_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [WDAY_W-1:0]  weekday;

  modport source (output valid, output year, output month, output day,
                  output weekday, input ready);
  modport sink (input valid, input year, input month, input day,
                input weekday, output ready);
endinterface

// ----- src/dri_out_if.sv -----
// result channel: valid/ready handshake with the selection fields
// depends on dri_pkg
interface dri_out_if import dri_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic              uses_custom;
  logic [BIDX_W-1:0] base_idx;
  logic [IDX_W-1:0]  pic_idx;

  modport source (output valid, output valid_res, output uses_custom,
                  output base_idx, output pic_idx, input ready);
  modport sink (input valid, input valid_res, input uses_custom,
                input base_idx, input pic_idx, output ready);
endinterface

// ----- src/dri_cfg_if.sv -----
// register write channel: valid/ready handshake with register index and data
// depends on dri_pkg
interface dri_cfg_if import dri_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/dri_date.sv -----
// two-stage date front end: range checks, leap year, civil day number
// depends on dri_pkg
module dri_date import dri_pkg::*; #(
  parameter int CW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               live_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  input  logic [WDAY_W-1:0]  weekday_i,
  input  logic [CW-1:0]      custom_i,
  input  logic [CW-1:0]      builtin_i,
  output dri_tag_t           tag_o,
  output logic [DNUM_W-1:0]  dnum_o
);

  // stage a: shifted year and the divisions by 100 and 400
  logic               a_live_r;
  logic [YEAR_W-1:0]  a_year_r;
  logic [YEAR_W-1:0]  a_yy_r;
  logic [MONTH_W-1:0] a_month_r;
  logic [DAY_W-1:0]   a_day_r;
  logic [WDAY_W-1:0]  a_wday_r;
  logic [QUOT_W-1:0]  a_q100y_r;
  logic [QUOT_W-1:0]  a_q100yy_r;
  logic [QUOT_W-1:0]  a_q400yy_r;

  logic [YEAR_W-1:0]  yy_nxt;

  always_comb begin
    yy_nxt = year_i - ((month_i <= MONTH_W'(2)) ? YEAR_W'(1) : YEAR_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_live_r <= 1'b0;
    end else if (adv) begin
      a_live_r <= live_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_year_r   <= year_i;
      a_yy_r     <= yy_nxt;
      a_month_r  <= month_i;
      a_day_r    <= day_i;
      a_wday_r   <= weekday_i;
      a_q100y_r  <= div25(year_i[YEAR_W-1:2]);
      a_q100yy_r <= div25(yy_nxt[YEAR_W-1:2]);
      a_q400yy_r <= div25({2'b00, yy_nxt[YEAR_W-1:4]});
    end
  end

  // stage b: validity and day number
  logic [14:0]       c100;
  logic              leap;
  logic [DAY_W-1:0]  mlen;
  logic              ok;
  logic [DNUM_W-1:0] dnum_nxt;
  dri_tag_t          tag_nxt;
  dri_tag_t          tag_r;
  logic [DNUM_W-1:0] dnum_r;

  always_comb begin
    c100 = 15'(a_q100y_r) * 15'd100;
    leap = (a_year_r[1:0] == 2'b00) &&
           ((c100 != {1'b0, a_year_r}) || (a_q100y_r[1:0] == 2'b00));
    mlen = month_len(leap, a_month_r);
    ok = (a_year_r >= YEAR_FIRST) && (a_year_r <= YEAR_LAST) &&
         (a_day_r != '0) && (a_day_r <= mlen) &&
         (a_wday_r < WDAY_LIMIT) && (builtin_i != '0);
    dnum_nxt = DNUM_W'(a_yy_r) * DNUM_W'(365) + DNUM_W'(a_yy_r[YEAR_W-1:2])
             - DNUM_W'(a_q100yy_r) + DNUM_W'(a_q400yy_r)
             + DNUM_W'(doy_base(a_month_r)) + DNUM_W'(a_day_r) - DNUM_W'(1);
    tag_nxt.live = a_live_r;
    tag_nxt.ok = ok;
    tag_nxt.uses_custom = ok && (custom_i != '0);
    tag_nxt.bidx = ok ? small_mod(a_wday_r, CFG_W'(builtin_i)) : '0;
  end

  // only the live bit is reset, the payload follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.live <= 1'b0;
    end else if (adv) begin
      tag_r.live <= tag_nxt.live;
    end
    if (adv) begin
      tag_r.ok          <= tag_nxt.ok;
      tag_r.uses_custom <= tag_nxt.uses_custom;
      tag_r.bidx        <= tag_nxt.bidx;
      dnum_r            <= dnum_nxt;
    end
  end

  assign tag_o  = tag_r;
  assign dnum_o = dnum_r;

endmodule

// ----- src/dri_cell.sv -----
// one restoring remainder cell: takes one dividend bit, conditionally subtracts
// depends on dri_pkg
module dri_cell import dri_pkg::*; #(
  parameter int CW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  dri_tag_t          tag_i,
  input  logic [DNUM_W-1:0] dvd_i,
  input  logic [CW-1:0]     rem_i,
  input  logic [CW-1:0]     div_i,
  output dri_tag_t          tag_o,
  output logic [DNUM_W-1:0] dvd_o,
  output logic [CW-1:0]     rem_o
);

  logic [CW:0]       trial;
  logic [CW:0]       diff;
  logic [CW-1:0]     rem_nxt;
  dri_tag_t          tag_r;
  logic [DNUM_W-1:0] dvd_r;
  logic [CW-1:0]     rem_r;

  always_comb begin
    trial = {rem_i, dvd_i[DNUM_W-1]};
    diff = trial - {1'b0, div_i};
    rem_nxt = (trial >= {1'b0, div_i}) ? diff[CW-1:0] : trial[CW-1:0];
  end

  // only the live bit is reset, the payload follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.live <= 1'b0;
    end else if (adv) begin
      tag_r.live <= tag_i.live;
    end
    if (adv) begin
      tag_r.ok          <= tag_i.ok;
      tag_r.uses_custom <= tag_i.uses_custom;
      tag_r.bidx        <= tag_i.bidx;
      dvd_r             <= {dvd_i[DNUM_W-2:0], 1'b0};
      rem_r             <= rem_nxt;
    end
  end

  assign tag_o = tag_r;
  assign dvd_o = dvd_r;
  assign rem_o = rem_r;

endmodule

// ----- src/date_rotation_index.sv -----
// date rotation index: picks a daily image index from a gregorian date. one
// beat is accepted per cycle and each gives exactly one result beat. on the
// way two front stages check the date and form the civil day number, then a
// row of 22 remainder cells (one per bit of the day number) reduces it modulo
// custom_count, then the output register. the whole row advances together, so
// a stalled result holds every stage; with the result side ready the block
// sustains one beat per cycle. registers are written through cfg_ch and must
// only change while no beat is in flight. depends on dri_pkg, the channel
// interfaces, dri_date and dri_cell
module date_rotation_index import dri_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  dri_in_if.sink   in_ch,
  dri_out_if.source out_ch,
  dri_cfg_if.sink  cfg_ch
);

  // counts are held at the narrower of the mask width and the register width
  localparam int CW = (COUNT_BITS < CFG_W) ? COUNT_BITS : CFG_W;

  // configuration registers
  logic [CW-1:0] custom_r;
  logic [CW-1:0] builtin_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      custom_r  <= '0;
      builtin_r <= CW'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CUSTOM:  custom_r <= cfg_ch.data[CW-1:0];
        REG_BUILTIN: builtin_r <= cfg_ch.data[CW-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // global advance: every stage moves when the output slot is free or taken
  logic adv;
  logic out_valid_r;

  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // front end
  dri_tag_t          front_tag;
  logic [DNUM_W-1:0] front_dnum;

  dri_date #(.CW(CW)) u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .live_i    (in_ch.valid),
    .year_i    (in_ch.year),
    .month_i   (in_ch.month),
    .day_i     (in_ch.day),
    .weekday_i (in_ch.weekday),
    .custom_i  (custom_r),
    .builtin_i (builtin_r),
    .tag_o     (front_tag),
    .dnum_o    (front_dnum)
  );

  // remainder row: cell k consumes dividend bit DNUM_W-1-k
  dri_tag_t          row_tag [DNUM_W+1];
  logic [DNUM_W-1:0] row_dvd [DNUM_W+1];
  logic [CW-1:0]     row_rem [DNUM_W+1];

  assign row_tag[0] = front_tag;
  assign row_dvd[0] = front_dnum;
  assign row_rem[0] = '0;

  for (genvar k = 0; k < DNUM_W; k++) begin : g_cell
    dri_cell #(.CW(CW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tag_i (row_tag[k]),
      .dvd_i (row_dvd[k]),
      .rem_i (row_rem[k]),
      .div_i (custom_r),
      .tag_o (row_tag[k+1]),
      .dvd_o (row_dvd[k+1]),
      .rem_o (row_rem[k+1])
    );
  end

  // output register
  dri_tag_t          last_tag;
  logic [IDX_W-1:0]  image_nxt;
  logic              res_ok_r;
  logic              uses_r;
  logic [BIDX_W-1:0] bidx_r;
  logic [IDX_W-1:0]  image_r;

  assign last_tag = row_tag[DNUM_W];

  // the row still carries a remainder for invalid beats, so select on uses_custom
  always_comb begin
    image_nxt = last_tag.uses_custom ? IDX_W'(row_rem[DNUM_W]) : IDX_W'(last_tag.bidx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last_tag.live;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_ok_r <= last_tag.ok;
      uses_r   <= last_tag.uses_custom;
      bidx_r   <= last_tag.bidx;
      image_r  <= image_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.valid_res   = res_ok_r;
  assign out_ch.uses_custom = uses_r;
  assign out_ch.base_idx    = bidx_r;
  assign out_ch.pic_idx     = image_r;

  // a rejected date carries all-zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_ok_r |-> !uses_r && bidx_r == '0 && image_r == '0)
    else $error("rejected beat with nonzero fields");

  // custom selection stays below the custom count
  a_custom_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && uses_r |-> image_r < IDX_W'(custom_r))
    else $error("custom image index out of range");

  // built-in index stays below the built-in count for accepted dates
  a_builtin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_ok_r |-> CFG_W'(bidx_r) < CFG_W'(builtin_r))
    else $error("builtin index out of range");

  // nothing comes out of the row right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

// ----- tb/tb_top.sv -----
// self-checking bench for date_rotation_index: directed dates, then random ones
// under several count settings, all checked beat by beat against typed picks or a local model
// depends on dri_pkg, the dri_in_if, dri_out_if and dri_cfg_if interfaces and the rtl
module tb_top;
  import dri_pkg::*;

  // run shape
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int PIPE_SETTLE     = 32;    // settle margin beyond the pipeline depth
  localparam int HOLD_CYCLES     = 200;   // long receiver hold-off, fills the pipe
  localparam int QUIET_LIMIT     = 3000;  // cycles without any beat before giving up
  localparam int COUNT_BITS      = COUNT_BITS_DEF;
  localparam int DATE_W          = YEAR_W + MONTH_W + DAY_W + WDAY_W;

  // register slots past the two real ones; writes there must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {
    RX_STREAM,  // always ready
    RX_COIN,    // ready on a coin flip
    RX_SPARSE,  // ready with a chance of one in four
    RX_COMB     // fixed repeating stall pattern
  } rx_mode_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
  } date_t;

  typedef struct packed {
    logic              valid_res;
    logic              uses_custom;
    logic [BIDX_W-1:0] base_idx;
    logic [IDX_W-1:0]  pic_idx;
  } pick_t;

  // one line of the directed table
  typedef struct {
    int unsigned custom;
    int unsigned builtin;
    date_t       dt;
    bit          known;  // expected pick typed in below
    pick_t       want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  dri_in_if  in_ch ();
  dri_out_if out_ch ();
  dri_cfg_if cfg_ch ();

  date_rotation_index u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the two count registers
  int unsigned custom_q;
  int unsigned builtin_q;

  pick_t       expected_picks[$];
  plan_row_t   plan_rows[$];
  int          fail_count;
  int          quiet_cycles;
  int          burst_left;
  int          gap_len;
  bit          hold_off_req;
  bit          hold_off_done;
  int          hold_left;
  int          mode_left;
  int unsigned rx_tick;
  rx_mode_t    rx_mode;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------- model

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
    int unsigned n;
    case (mo)
      2:             n = is_leap(yr) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      1, 3, 5, 7, 8,
      10, 12:        n = 31;
      default:       n = 0;
    endcase
    return n;
  endfunction

  // days-from-civil count with march-based years, no epoch shift
  function automatic int unsigned civil_day(input int unsigned yr, input int unsigned mo,
                                            input int unsigned dy);
    int unsigned yy;
    int unsigned era;
    int unsigned yoe;
    int unsigned mp;
    int unsigned doy;
    int unsigned doe;
    yy  = yr - ((mo <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (mo > 2) ? (mo - 3) : (mo + 9);
    doy = (153 * mp + 2) / 5 + (dy - 1);
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe;
  endfunction

  function automatic pick_t predict_pick(input date_t dt);
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned wd;
    int unsigned bidx;
    int unsigned idx;
    bit          ok;
    pick_t       p;
    yr = dt.year;
    mo = dt.month;
    dy = dt.day;
    wd = dt.weekday;
    ok = (yr >= YEAR_FIRST) && (yr <= YEAR_LAST) && (dy >= 1) &&
         (dy <= month_length(yr, mo)) && (wd < WDAY_LIMIT) && (builtin_q != 0);
    p = '0;
    if (ok) begin
      bidx = wd % builtin_q;
      idx  = (custom_q != 0) ? civil_day(yr, mo, dy) % custom_q : bidx;
      p.valid_res   = 1'b1;
      p.uses_custom = (custom_q != 0);
      p.base_idx    = BIDX_W'(bidx);
      p.pic_idx     = IDX_W'(idx);
    end
    return p;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // result side: compare every accepted beat with the oldest expectation
  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_picks.size() == 0) begin
        report_mismatch("result beat with nothing pending, pic_idx",
                        int'(out_ch.pic_idx), 0);
      end else begin
        want = expected_picks.pop_front();
        if (out_ch.valid_res !== want.valid_res)
          report_mismatch("valid_res", int'(out_ch.valid_res), int'(want.valid_res));
        if (out_ch.uses_custom !== want.uses_custom)
          report_mismatch("uses_custom", int'(out_ch.uses_custom), int'(want.uses_custom));
        if (out_ch.base_idx !== want.base_idx)
          report_mismatch("base_idx", int'(out_ch.base_idx), int'(want.base_idx));
        if (out_ch.pic_idx !== want.pic_idx)
          report_mismatch("pic_idx", int'(out_ch.pic_idx), int'(want.pic_idx));
      end
    end
  end

  // watchdog: any beat on any channel restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- receiver

  // stall pattern changes mode after a random run length; one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    mode_left    = 0;
    rx_tick      = 0;
    rx_mode      = RX_STREAM;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_off_req && !hold_off_done) begin
        hold_left     = HOLD_CYCLES;
        hold_off_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          RX_STREAM: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= (rx_tick % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- sender side

  // offer one date; bursts of back-to-back beats with random gaps between them
  task automatic offer_date(input date_t dt, input bit known, input pick_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.year    <= dt.year;
    in_ch.month   <= dt.month;
    in_ch.day     <= dt.day;
    in_ch.weekday <= dt.weekday;
    do @(posedge clk); while (!in_ch.ready);
    expected_picks.push_back(known ? want : predict_pick(dt));
  endtask

  // stop offering and let every beat in flight come out
  task automatic drain_pipe();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] wdata);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= wdata;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_CUSTOM:  custom_q  = wdata & ((1 << COUNT_BITS) - 1);
      REG_BUILTIN: builtin_q = wdata & ((1 << COUNT_BITS) - 1);
      default: ;  // unused slot, nothing changes
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // new counts only once the block is empty; a junk write to a spare slot rides along
  task automatic apply_counts(input int unsigned cust, input int unsigned bltn);
    drain_pipe();
    write_reg(REG_CUSTOM, CFG_W'(cust));
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
    write_reg(REG_BUILTIN, CFG_W'(bltn));
  endtask

  task automatic add_row(input int unsigned cust, input int unsigned bltn,
                         input int unsigned yr, input int unsigned mo,
                         input int unsigned dy, input int unsigned wd,
                         input bit known, input bit v, input bit u,
                         input int unsigned bidx, input int unsigned idx);
    plan_row_t r;
    r.custom  = cust;
    r.builtin = bltn;
    r.dt      = {YEAR_W'(yr), MONTH_W'(mo), DAY_W'(dy), WDAY_W'(wd)};
    r.known   = known;
    r.want    = {v, u, BIDX_W'(bidx), IDX_W'(idx)};
    plan_rows.push_back(r);
  endtask

  // mostly legal dates with random content, the rest broken or plain noise
  function automatic date_t pick_random_date();
    date_t       dt;
    int unsigned flavor;
    int unsigned mlen;
    flavor = $urandom_range(0, 99);
    if (flavor < 8) begin
      case ($urandom_range(0, 5))
        0:       dt.year = YEAR_W'(1970);
        1:       dt.year = YEAR_W'(9999);
        2:       dt.year = YEAR_W'(2000);
        3:       dt.year = YEAR_W'(2100);
        4:       dt.year = YEAR_W'(2400);
        default: dt.year = YEAR_W'($urandom_range(1970, 1975));
      endcase
    end else begin
      dt.year = YEAR_W'($urandom_range(1970, 9999));
    end
    dt.month   = MONTH_W'($urandom_range(1, 12));
    mlen       = month_length(dt.year, dt.month);
    dt.day     = DAY_W'($urandom_range(1, mlen));
    dt.weekday = WDAY_W'($urandom_range(0, 6));
    if (flavor >= 8 && flavor < 16) begin
      // month ends, leap day included
      dt.day = DAY_W'(mlen);
    end else if (flavor >= 85 && flavor < 93) begin
      // one field out of range
      case ($urandom_range(0, 3))
        0: dt.year = $urandom_range(0, 1) ? YEAR_W'($urandom_range(0, 1969))
                                          : YEAR_W'($urandom_range(10000, 16383));
        1: dt.month = MONTH_W'($urandom_range(13, 16));  // 13..15 or 0
        2: dt.day = (mlen == 31 || $urandom_range(0, 1)) ? DAY_W'(0)
                                                         : DAY_W'($urandom_range(mlen + 1, 31));
        default: dt.weekday = WDAY_W'(7);
      endcase
    end else if (flavor >= 93) begin
      dt = date_t'(DATE_W'($urandom));
    end
    return dt;
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.year    = '0;
    in_ch.month   = '0;
    in_ch.day     = '0;
    in_ch.weekday = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_CUSTOM;
    cfg_ch.data   = '0;
    custom_q      = 0;
    builtin_q     = 1;
    fail_count    = 0;
    quiet_cycles  = 0;
    burst_left    = 0;
    hold_off_req  = 1'b0;
    hold_off_done = 1'b0;

    // directed table: counts, date, weekday, then the typed pick where it is obvious
    //      cust bltn  year mo dy wd  known v u bidx idx
    // reset counts: built-in set of one, so every legal date picks zero
    add_row(0,   1,   1970,  1,  1, 0,  1, 1, 0, 0, 0);   // first legal day
    add_row(0,   1,   9999, 12, 31, 6,  1, 1, 0, 0, 0);   // last legal day
    add_row(0,   1,   1969, 12, 31, 3,  1, 0, 0, 0, 0);   // year too early
    add_row(0,   1,  10000,  1,  1, 2,  1, 0, 0, 0, 0);   // year too late
    add_row(0,   1,  16383, 15, 31, 7,  1, 0, 0, 0, 0);   // every field at its top
    add_row(0,   1,      0,  0,  0, 0,  1, 0, 0, 0, 0);   // every field zero
    add_row(0,   1,   2000,  2, 29, 4,  1, 1, 0, 0, 0);   // leap day, 400 rule
    add_row(0,   1,   2100,  2, 29, 1,  1, 0, 0, 0, 0);   // century, not leap
    add_row(0,   1,   2023,  2, 29, 1,  1, 0, 0, 0, 0);   // plain non-leap year
    add_row(0,   1,   2024,  2, 29, 3,  1, 1, 0, 0, 0);   // plain leap year
    add_row(0,   1,   2024,  4, 31, 5,  1, 0, 0, 0, 0);   // day past a 30 day month
    add_row(0,   1,   2024,  4, 30, 5,  1, 1, 0, 0, 0);
    add_row(0,   1,   2024, 13,  1, 5,  1, 0, 0, 0, 0);   // month past december
    add_row(0,   1,   2024,  5,  0, 5,  1, 0, 0, 0, 0);   // day zero
    add_row(0,   1,   2024,  6, 15, 7,  1, 0, 0, 0, 0);   // weekday out of range
    // large custom gallery: day number modulo, left to the model
    add_row(255, 7,   1970,  1,  1, 6,  0, 0, 0, 0, 0);
    add_row(255, 7,   9999, 12, 31, 6,  0, 0, 0, 0, 0);
    add_row(255, 7,   2000,  3,  1, 5,  0, 0, 0, 0, 0);
    add_row(255, 7,   2024,  2, 29, 0,  0, 0, 0, 0, 0);
    add_row(255, 7,   2023,  2, 29, 3,  1, 0, 0, 0, 0);   // invalid clears uses_custom
    // gallery of one: anything modulo one is zero
    add_row(1,   1,   2024,  7,  4, 6,  1, 1, 1, 0, 0);
    // no built-in images: every request invalid
    add_row(0,   0,   2024,  7,  4, 6,  1, 0, 0, 0, 0);
    add_row(0,   0,   2000,  1,  1, 0,  1, 0, 0, 0, 0);
    // wide built-in set: weekday passes straight through
    add_row(0,   255, 1999, 12, 31, 6,  1, 1, 0, 6, 6);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan_rows[i]) begin
      if (plan_rows[i].custom != custom_q || plan_rows[i].builtin != builtin_q)
        apply_counts(plan_rows[i].custom, plan_rows[i].builtin);
      offer_date(plan_rows[i].dt, plan_rows[i].known, plan_rows[i].want);
    end

    // random phases, each under its own pair of counts
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       apply_counts(0, 255);
        1:       apply_counts(255, 255);
        2:       apply_counts(3, 7);
        3:       apply_counts(1, 1);
        4:       apply_counts(0, 0);
        5:       apply_counts(254, 2);
        default: apply_counts($urandom_range(0, 255), $urandom_range(0, 255));
      endcase
      // long hold-off while the sender keeps going, backs the pipe up to the input
      if (phase == 2)
        hold_off_req = 1'b1;
      repeat (ITEMS_PER_PHASE) offer_date(pick_random_date(), 1'b0, '0);
    end

    drain_pipe();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
